// ===== rtl/bsp_pkg.sv =====
// Shared types, constants and helpers of the billboard sprite projector.
`default_nettype none

package bsp_pkg;

  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 480;
  localparam int MASK_BITS_DEF     = 64;
  localparam int MAX_RUNS          = 16;
  localparam int COL_W             = 10;
  localparam int DVD_W             = 80;

  // floor(u / 125) = (u * RECIP) >> 38 for any u below 2^31
  localparam logic [32:0] RECIP = 33'd2199023256;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // multiplier operand selections
  localparam logic [3:0] MUL_DET_P = 4'd0;
  localparam logic [3:0] MUL_DET_Q = 4'd1;
  localparam logic [3:0] MUL_NX_P  = 4'd2;
  localparam logic [3:0] MUL_NX_Q  = 4'd3;
  localparam logic [3:0] MUL_NY_P  = 4'd4;
  localparam logic [3:0] MUL_NY_Q  = 4'd5;
  localparam logic [3:0] MUL_TIME  = 4'd6;
  localparam logic [3:0] MUL_HX_LO = 4'd7;
  localparam logic [3:0] MUL_HX_HI = 4'd8;
  localparam logic [3:0] MUL_HD_LO = 4'd9;
  localparam logic [3:0] MUL_HD_HI = 4'd10;

  // divide phases
  localparam logic [1:0] PH_SX  = 2'd0;
  localparam logic [1:0] PH_H   = 2'd1;
  localparam logic [1:0] PH_THR = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [9:0]         column;
    logic [31:0]        depth;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] viewer_x;
    logic signed [31:0] viewer_y;
    logic signed [31:0] facing_x;
    logic signed [31:0] facing_y;
    logic signed [31:0] lens_x;
    logic signed [31:0] lens_y;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic        visible;
    logic [9:0]  left_col;
    logic [9:0]  right_col;
    logic [9:0]  top_row;
    logic [9:0]  bottom_row;
    logic [23:0] colour;
    logic [9:0]  mask_base;
    logic [63:0] column_mask;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       clr_step;
    logic       wr_en;
    logic       capture;
    logic       prep;
    logic       mul_issue;
    logic [3:0] mul_idx;
    logic       div_load_thr;
    logic       div_start;
    logic       div_store;
    logic [1:0] div_phase;
    logic       bounds;
    logic       run_init;
    logic       col_step;
    logic       run_next;
    logic       out_load;
    logic       out_rej;
  } bsp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rej;
    logic div_done;
    logic col_last;
    logic more;
    logic out_free;
  } bsp_stat_t;

  function automatic logic [23:0] colour_of(input logic [1:0] idx);
    logic [23:0] c;
    unique case (idx)
      2'd0:    c = 24'hFF3333;
      2'd1:    c = 24'hFF9900;
      2'd2:    c = 24'hFFFF00;
      default: c = 24'hFF00AA;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bsp_div.sv =====
// Restoring divider, one quotient bit per cycle, with overflow detect.
`default_nettype none

module bsp_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [bsp_pkg::DVD_W-1:0]   dividend,
  input  wire logic [63:0]                 divisor,
  output logic                             busy,
  output logic                             done,
  output logic [63:0]                      quo,
  output logic                             rem_nz,
  output logic                             ovf
);

  logic        busy_r, done_r, ovf_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r, dl_r, q_r, d_r;
  logic [64:0] rem2;
  logic [65:0] diff;
  logic        ge, ovf_w;

  always_comb begin
    ovf_w = {48'd0, dividend[bsp_pkg::DVD_W-1:64]} >= divisor;
    rem2  = {rem_r, dl_r[63]};
    diff  = {1'b0, rem2} - {2'b00, d_r};
    ge    = !diff[65];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= !ovf_w;
      done_r <= ovf_w;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= divisor;
      rem_r <= {48'd0, dividend[bsp_pkg::DVD_W-1:64]};
      dl_r  <= dividend[63:0];
      q_r   <= '0;
      ovf_r <= ovf_w;
    end else if (busy_r) begin
      rem_r <= ge ? diff[63:0] : rem2[63:0];
      q_r   <= {q_r[62:0], ge};
      dl_r  <= {dl_r[62:0], 1'b0};
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign quo    = q_r;
  assign rem_nz = (rem_r != 64'd0);
  assign ovf    = ovf_r;

endmodule

`default_nettype wire

// ===== rtl/bsp_dpath.sv =====
// Datapath: depth store, shared multiplier, divider, bounds, mask walk, result register.
`default_nettype none

module bsp_dpath #(
  parameter int SCREEN_WIDTH  = bsp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = bsp_pkg::SCREEN_HEIGHT_DEF,
  parameter int MASK_BITS     = bsp_pkg::MASK_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bsp_pkg::in_item_t  in_item,
  input  wire bsp_pkg::bsp_cmd_t  cmd,
  output bsp_pkg::bsp_stat_t      stat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bsp_pkg::out_item_t      out_item
);

  localparam int AW     = $clog2(SCREEN_WIDTH);
  localparam int IW     = $clog2(MASK_BITS);
  localparam int HALF_W = SCREEN_WIDTH / 2;
  localparam int HALF_H = SCREEN_HEIGHT / 2;

  // depth store
  logic [31:0]    mem [SCREEN_WIDTH];
  logic [AW-1:0]  clr_idx_r;
  logic           wr_en, col_ok;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [31:0]    wr_data, rd_data_r;
  logic           rd_vld_r;
  logic [IW-1:0]  rd_bit_r;

  bsp_pkg::in_item_t item_r;
  logic signed [31:0] dx_r, dy_r;
  logic signed [32:0] dx_w, dy_w;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic [3:0]         tag_r;
  logic               tvld_r;
  logic signed [63:0] hold_r;
  logic signed [64:0] pdiff;
  logic               pneg;
  logic [63:0]        pmag;

  logic [63:0] det_r, numx_r, numy_r, plo_r;
  logic        det_neg_r, numx_neg_r, numy_neg_r;
  logic [1:0]  cidx_r;
  logic [bsp_pkg::DVD_W-1:0] dvd_r;

  logic        div_busy, div_done, div_rem_nz, div_ovf;
  logic [63:0] div_quo;

  logic signed [31:0] sx_r, sx_w;
  logic [30:0]        h_r, h_w;
  logic [31:0]        thr_r;
  logic               thr_ovf_r;
  logic [34:0]        r35;
  logic               inexact, pos_case, mid_case;
  logic signed [35:0] half36, r36, sum36, dif36, adj36;

  logic [bsp_pkg::COL_W-1:0] left_r, right_r, top_r, bottom_r;
  logic [29:0]        hh;
  logic signed [33:0] s0, e0;
  logic [30:0]        ey_sum;

  logic [10:0]          base_r, col_c, base_step;
  logic [IW-1:0]        col_i_r;
  logic [3:0]           run_r;
  logic [MASK_BITS-1:0] mask_r;
  logic                 in_rng, more;

  logic                 out_valid_r;
  bsp_pkg::out_item_t   out_r;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -36'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = v[31:0];
    return r;
  endfunction

  // ---- depth store writes and reads
  always_comb begin
    col_ok  = {1'b0, in_item.column} < 11'(SCREEN_WIDTH);
    wr_en   = cmd.clr_step || (cmd.wr_en && col_ok);
    wr_addr = cmd.clr_step ? clr_idx_r : in_item.column[AW-1:0];
    wr_data = cmd.clr_step ? 32'd0 : in_item.depth;
    col_c   = base_r + 11'(col_i_r);
    in_rng  = col_c < {1'b0, right_r};
    rd_addr = col_c[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      rd_vld_r  <= 1'b0;
      tvld_r    <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_idx_r <= clr_idx_r + AW'(1);
      rd_vld_r <= cmd.col_step && in_rng;
      tvld_r   <= cmd.mul_issue;
    end
  end

  // ---- item capture and offsets
  always_comb begin
    dx_w = $signed({item_r.target_x[31], item_r.target_x})
         - $signed({item_r.viewer_x[31], item_r.viewer_x});
    dy_w = $signed({item_r.target_y[31], item_r.target_y})
         - $signed({item_r.viewer_y[31], item_r.viewer_y});
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    if (cmd.prep) begin
      dx_r <= sat32(36'(dx_w));
      dy_r <= sat32(36'(dy_w));
    end
  end

  // ---- shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_idx)
      bsp_pkg::MUL_DET_P: begin
        mul_a = {item_r.lens_x[31], item_r.lens_x};
        mul_b = {item_r.facing_y[31], item_r.facing_y};
      end
      bsp_pkg::MUL_DET_Q: begin
        mul_a = {item_r.facing_x[31], item_r.facing_x};
        mul_b = {item_r.lens_y[31], item_r.lens_y};
      end
      bsp_pkg::MUL_NX_P: begin
        mul_a = {item_r.facing_y[31], item_r.facing_y};
        mul_b = {dx_r[31], dx_r};
      end
      bsp_pkg::MUL_NX_Q: begin
        mul_a = {item_r.facing_x[31], item_r.facing_x};
        mul_b = {dy_r[31], dy_r};
      end
      bsp_pkg::MUL_NY_P: begin
        mul_a = {item_r.lens_x[31], item_r.lens_x};
        mul_b = {dy_r[31], dy_r};
      end
      bsp_pkg::MUL_NY_Q: begin
        mul_a = {item_r.lens_y[31], item_r.lens_y};
        mul_b = {dx_r[31], dx_r};
      end
      bsp_pkg::MUL_TIME: begin
        mul_a = {2'b00, item_r.time_ms[31:1]};
        mul_b = bsp_pkg::RECIP;
      end
      bsp_pkg::MUL_HX_LO: begin
        mul_a = 33'(HALF_W);
        mul_b = {1'b0, numx_r[31:0]};
      end
      bsp_pkg::MUL_HX_HI: begin
        mul_a = 33'(HALF_W);
        mul_b = {1'b0, numx_r[63:32]};
      end
      bsp_pkg::MUL_HD_LO: begin
        mul_a = 33'(SCREEN_HEIGHT);
        mul_b = {1'b0, det_r[31:0]};
      end
      bsp_pkg::MUL_HD_HI: begin
        mul_a = 33'(SCREEN_HEIGHT);
        mul_b = {1'b0, det_r[63:32]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    tag_r  <= cmd.mul_idx;
  end

  // product difference: sign and magnitude
  always_comb begin
    pdiff = {hold_r[63], hold_r} - {prod_r[63], prod_r[63:0]};
    pneg  = pdiff[64];
    pmag  = pneg ? 64'(-pdiff) : pdiff[63:0];
  end

  always_ff @(posedge clk) begin
    if (tvld_r) begin
      case (tag_r)
        bsp_pkg::MUL_DET_P, bsp_pkg::MUL_NX_P, bsp_pkg::MUL_NY_P: hold_r <= prod_r[63:0];
        bsp_pkg::MUL_DET_Q: begin
          det_r     <= pmag;
          det_neg_r <= pneg;
        end
        bsp_pkg::MUL_NX_Q: begin
          numx_r     <= pmag;
          numx_neg_r <= pneg;
        end
        bsp_pkg::MUL_NY_Q: begin
          numy_r     <= pmag;
          numy_neg_r <= pneg;
        end
        bsp_pkg::MUL_TIME: cidx_r <= prod_r[39:38];
        bsp_pkg::MUL_HX_LO, bsp_pkg::MUL_HD_LO: plo_r <= prod_r[63:0];
        bsp_pkg::MUL_HX_HI, bsp_pkg::MUL_HD_HI:
          dvd_r <= {16'd0, plo_r} + {prod_r[47:0], 32'd0};
        default: ;
      endcase
    end
    if (cmd.div_load_thr) dvd_r <= {numy_r, 16'd0};
  end

  // ---- divider
  bsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd_r),
    .divisor  ((cmd.div_phase == bsp_pkg::PH_THR) ? det_r : numy_r),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo),
    .rem_nz   (div_rem_nz),
    .ovf      (div_ovf)
  );

  // screen centre column and sprite height from the quotient
  always_comb begin
    if (div_ovf || div_quo > 64'h2_0000_0000) r35 = 35'h2_0000_0000;
    else                                      r35 = div_quo[34:0];
    inexact  = div_ovf || div_rem_nz;
    half36   = 36'(HALF_W);
    r36      = $signed({1'b0, r35});
    sum36    = half36 + r36;
    dif36    = half36 - r36;
    adj36    = dif36 - 36'(inexact);
    pos_case = (numx_r == 64'd0) || (numx_neg_r == numy_neg_r);
    mid_case = (r35 < 35'(HALF_W)) || ((r35 == 35'(HALF_W)) && !inexact);
    if (pos_case)      sx_w = sat32(sum36);
    else if (mid_case) sx_w = adj36[31:0];
    else               sx_w = sat32(dif36);
    if (div_ovf || div_quo > 64'h7FFF_FFFF) h_w = 31'h7FFF_FFFF;
    else                                     h_w = div_quo[30:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_phase)
        bsp_pkg::PH_SX: sx_r <= sx_w;
        bsp_pkg::PH_H:  h_r  <= h_w;
        default: begin
          thr_ovf_r <= div_ovf || (div_quo[63:32] != 32'd0);
          thr_r     <= div_quo[31:0];
        end
      endcase
    end
  end

  // ---- bounds
  always_comb begin
    hh     = h_r[30:1];
    ey_sum = {1'b0, hh} + 31'(HALF_H);
    s0     = $signed({sx_r[31], sx_r[31], sx_r}) - $signed({4'd0, hh});
    e0     = $signed({sx_r[31], sx_r[31], sx_r}) + $signed({4'd0, hh});
  end

  always_ff @(posedge clk) begin
    if (cmd.bounds) begin
      if (hh >= 30'(HALF_H)) top_r <= '0;
      else                   top_r <= bsp_pkg::COL_W'(30'(HALF_H) - hh);
      if (ey_sum >= 31'(SCREEN_HEIGHT)) bottom_r <= bsp_pkg::COL_W'(SCREEN_HEIGHT - 1);
      else                              bottom_r <= ey_sum[bsp_pkg::COL_W-1:0];
      if (s0 < 34'sd0)                              left_r <= '0;
      else if (s0 > $signed(34'(SCREEN_WIDTH - 1))) left_r <= bsp_pkg::COL_W'(SCREEN_WIDTH - 1);
      else                                          left_r <= s0[bsp_pkg::COL_W-1:0];
      if (e0 > $signed(34'(SCREEN_WIDTH - 1))) right_r <= bsp_pkg::COL_W'(SCREEN_WIDTH - 1);
      else if (e0 < 34'sd0)                    right_r <= '0;
      else                                     right_r <= e0[bsp_pkg::COL_W-1:0];
    end
  end

  // ---- mask walk
  always_comb begin
    base_step = base_r + 11'(MASK_BITS);
    more      = (base_step < {1'b0, right_r}) && (run_r != 4'(bsp_pkg::MAX_RUNS - 1));
  end

  always_ff @(posedge clk) begin
    rd_bit_r <= col_i_r;
    if (cmd.run_init) begin
      base_r  <= {1'b0, left_r};
      run_r   <= '0;
      col_i_r <= '0;
      mask_r  <= '0;
    end else if (cmd.run_next) begin
      base_r  <= base_step;
      run_r   <= run_r + 4'd1;
      col_i_r <= '0;
      mask_r  <= '0;
    end else begin
      if (cmd.col_step) col_i_r <= col_i_r + IW'(1);
      if (rd_vld_r && !thr_ovf_r && (rd_data_r > thr_r)) mask_r[rd_bit_r] <= 1'b1;
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_rej) begin
        // rejected sprite: everything zero but the last flag
        out_r <= '{visible: 1'b0, left_col: '0, right_col: '0, top_row: '0,
                   bottom_row: '0, colour: '0, mask_base: '0, column_mask: '0,
                   last: 1'b1};
      end else begin
        out_r.visible     <= 1'b1;
        out_r.left_col    <= left_r;
        out_r.right_col   <= right_r;
        out_r.top_row     <= top_r;
        out_r.bottom_row  <= bottom_r;
        out_r.colour      <= bsp_pkg::colour_of(cidx_r);
        out_r.mask_base   <= base_r[9:0];
        out_r.column_mask <= 64'(mask_r);
        out_r.last        <= !more;
      end
    end
  end

  always_comb begin
    stat.clr_last = (clr_idx_r == AW'(SCREEN_WIDTH - 1));
    stat.rej      = (det_r == 64'd0) || (numy_r == 64'd0) || (det_neg_r != numy_neg_r);
    stat.div_done = div_done;
    stat.col_last = (col_i_r == IW'(MASK_BITS - 1));
    stat.more     = more;
    stat.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over an untaken item");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_wr_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !cmd.clr_step)
    else $error("depth write during clearing pass");

endmodule

`default_nettype wire

// ===== rtl/bsp_ctrl.sv =====
// Controller: sequences clearing, multiplies, divides, bounds and mask runs.
`default_nettype none

module bsp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_op,
  output logic                    in_stall,
  output bsp_pkg::bsp_cmd_t       cmd,
  input  wire bsp_pkg::bsp_stat_t stat
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_PREP    = 4'd2;
  localparam logic [3:0] S_MUL     = 4'd3;
  localparam logic [3:0] S_DRAIN   = 4'd4;
  localparam logic [3:0] S_CHECK   = 4'd5;
  localparam logic [3:0] S_REJ     = 4'd6;
  localparam logic [3:0] S_PLO     = 4'd7;
  localparam logic [3:0] S_PHI     = 4'd8;
  localparam logic [3:0] S_PSUM    = 4'd9;
  localparam logic [3:0] S_TLOAD   = 4'd10;
  localparam logic [3:0] S_DSTART  = 4'd11;
  localparam logic [3:0] S_DWAIT   = 4'd12;
  localparam logic [3:0] S_BOUNDS  = 4'd13;
  localparam logic [3:0] S_COL     = 4'd14;
  localparam logic [3:0] S_EMIT    = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       tail_r, tail_nxt;  // marks the extra step after the last column read

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    tail_nxt  = tail_r;
    cmd.div_phase = phase_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == bsp_pkg::OP_PROJECT) begin
            cmd.capture = 1'b1;
            state_nxt   = S_PREP;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_idx   = {1'b0, cnt_r};
        cnt_nxt       = cnt_r + 3'd1;
        if (4'({1'b0, cnt_r}) == bsp_pkg::MUL_TIME) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_CHECK;
      S_CHECK: begin
        phase_nxt = bsp_pkg::PH_SX;
        state_nxt = stat.rej ? S_REJ : S_PLO;
      end
      S_REJ: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_rej  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_PLO: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_idx   = (phase_r == bsp_pkg::PH_SX) ? bsp_pkg::MUL_HX_LO : bsp_pkg::MUL_HD_LO;
        state_nxt     = S_PHI;
      end
      S_PHI: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_idx   = (phase_r == bsp_pkg::PH_SX) ? bsp_pkg::MUL_HX_HI : bsp_pkg::MUL_HD_HI;
        state_nxt     = S_PSUM;
      end
      S_PSUM: state_nxt = S_DSTART;
      S_TLOAD: begin
        cmd.div_load_thr = 1'b1;
        state_nxt        = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          unique case (phase_r)
            bsp_pkg::PH_SX: begin
              phase_nxt = bsp_pkg::PH_H;
              state_nxt = S_PLO;
            end
            bsp_pkg::PH_H: state_nxt = S_BOUNDS;
            default: state_nxt = S_COL;
          endcase
          if (phase_r == bsp_pkg::PH_THR) begin
            tail_nxt = 1'b0;
          end
        end
      end
      S_BOUNDS: begin
        cmd.bounds = 1'b1;
        phase_nxt  = bsp_pkg::PH_THR;
        state_nxt  = S_TLOAD;
      end
      S_COL: begin
        // first cycle after the threshold divide sets up the first run
        if (phase_r == bsp_pkg::PH_THR) begin
          cmd.run_init = 1'b1;
          phase_nxt    = bsp_pkg::PH_SX;
        end else if (tail_r) begin
          tail_nxt  = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          cmd.col_step = 1'b1;
          if (stat.col_last) tail_nxt = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.more) begin
            cmd.run_next = 1'b1;
            state_nxt    = S_COL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      phase_r <= bsp_pkg::PH_SX;
      tail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      tail_r  <= tail_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/billboard_sprite_projector_unit.sv =====
// Top level of the billboard sprite projector: controller plus datapath.
// Depth write: taken while idle, no result; back-to-back writes every cycle while idle.
// Projection: first run leaves after the multiplies and then three divides, each further
//   run after its own column walk, up to 16 runs.
// Rejected sprite: its single result leaves after the multiplies and the check.
// Input stalls until the last run is in the result register; writes resume while it waits.
// Reset (rst_n low, synchronous): a clearing pass over all SCREEN_WIDTH entries zeroes the
//   depth store, during which in_stall stays high.
`default_nettype none

module billboard_sprite_projector_unit #(
  parameter int SCREEN_WIDTH  = bsp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = bsp_pkg::SCREEN_HEIGHT_DEF,
  parameter int MASK_BITS     = bsp_pkg::MASK_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // item input: depth writes and projection requests
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bsp_pkg::in_item_t  in_item,
  // result output: one or more mask runs per projection
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bsp_pkg::out_item_t      out_item
);

  bsp_pkg::bsp_cmd_t  cmd;
  bsp_pkg::bsp_stat_t stat;

  // Controller owns sequencing only: it sees the handshake and the item's operation bit,
  // and steers the datapath through the command struct.
  bsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_item.operation),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Datapath holds the depth store, the shared 33x33 multiplier, the divider,
  // the bounds logic, the column walk and the result register.
  bsp_dpath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MASK_BITS     (MASK_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
